@@ hw/rtl/per_channel_scalar_kalman_filter_core_defines.svh @@
// assertion macros shared by the kalman filter rtl
`ifndef PER_CHANNEL_SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH
`define PER_CHANNEL_SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH

// same-cycle implication, checked on clk, off while in reset
`define PSKF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off while in reset
`define PSKF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/pskf_pkg.sv @@
// shared types, widths and constants of the kalman filter core
package pskf_pkg;

  localparam int NUM_CHANNELS = 16;

  localparam int CHANNEL_W   = 4;
  localparam int CHANNEL_CNT = 1 << CHANNEL_W;
  // only channels reachable through the channel field need storage
  localparam int STORE_DEPTH = (NUM_CHANNELS < CHANNEL_CNT) ? NUM_CHANNELS : CHANNEL_CNT;
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int VAR_W    = 24;
  localparam int PRED_W   = VAR_W + 1;
  localparam int DENOM_W  = VAR_W + 2;
  localparam int REM_W    = DENOM_W + 1;
  localparam int GAIN_W   = FRAC_W + 1;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int PROD_D_W = GAIN_W + DIFF_W;
  localparam int PROD_P_W = GAIN_W + PRED_W;
  localparam int CNT_W    = $clog2(GAIN_W);
  localparam int CFG_IDX_W = 1;

  localparam logic [VAR_W-1:0]  VAR_RESET = VAR_W'(65536);
  localparam logic [VAR_W-1:0]  VAR_MAX   = '1;
  localparam logic [VAR_W-1:0]  Q_RESET   = VAR_W'(1442);
  localparam logic [VAR_W-1:0]  R_RESET   = VAR_W'(40436);
  localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(65536);

  typedef logic [CHANNEL_CNT-1:0][IDX_W-1:0] ch_map_t;

  function automatic ch_map_t build_ch_map();
    ch_map_t m;
    for (int i = 0; i < CHANNEL_CNT; i++) begin
      m[i] = IDX_W'(i % NUM_CHANNELS);
    end
    return m;
  endfunction

  // channel field to store row, wrapping past the channel count
  localparam ch_map_t CH_MAP = build_ch_map();

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROCESS_NOISE     = 1'b0,
    REG_OBSERVATION_NOISE = 1'b1
  } pskf_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_START,
    ST_DIV,
    ST_FIN
  } pskf_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pskf_div_status_t;

endpackage

@@ hw/rtl/pskf_var_store.sv @@
// per-channel error variance registers with reset to 1.0
module pskf_var_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pskf_pkg::IDX_W-1:0]    rd_idx,
  output logic [pskf_pkg::VAR_W-1:0]    rd_data,
  input  logic                          wr_en,
  input  logic [pskf_pkg::IDX_W-1:0]    wr_idx,
  input  logic [pskf_pkg::VAR_W-1:0]    wr_data
);

  logic [pskf_pkg::VAR_W-1:0] var_r [pskf_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pskf_pkg::STORE_DEPTH; i++) begin
        var_r[i] <= pskf_pkg::VAR_RESET;
      end
    end else if (wr_en) begin
      var_r[wr_idx] <= wr_data;
    end
  end

  assign rd_data = var_r[rd_idx];

endmodule

@@ hw/rtl/pskf_serial_div.sv @@
// bit-serial gain divider with the two products accumulated msb first
module pskf_serial_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [pskf_pkg::PRED_W-1:0]           pred,
  input  logic [pskf_pkg::DENOM_W-1:0]          denom,
  input  logic signed [pskf_pkg::DIFF_W-1:0]    diff,
  output pskf_pkg::pskf_div_status_t            status,
  output logic [pskf_pkg::GAIN_W-1:0]           gain,
  output logic [pskf_pkg::PROD_P_W-1:0]         prod_pred,
  output logic signed [pskf_pkg::PROD_D_W-1:0]  prod_diff
);

  logic                                  busy_r, busy_nxt;
  logic                                  done_r, done_nxt;
  logic [pskf_pkg::CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                                  zero_r, zero_nxt;
  logic [pskf_pkg::REM_W-1:0]            rem_r, rem_nxt;
  logic [pskf_pkg::DENOM_W-1:0]          den_r, den_nxt;
  logic [pskf_pkg::PRED_W-1:0]           pred_r, pred_nxt;
  logic signed [pskf_pkg::DIFF_W-1:0]    diff_r, diff_nxt;
  logic [pskf_pkg::GAIN_W-1:0]           quo_r, quo_nxt;
  logic [pskf_pkg::PROD_P_W-1:0]         acc_p_r, acc_p_nxt;
  logic signed [pskf_pkg::PROD_D_W-1:0]  acc_d_r, acc_d_nxt;

  logic                                  ge;
  logic                                  qbit;
  logic [pskf_pkg::REM_W-1:0]            den_ext;
  logic [pskf_pkg::REM_W-1:0]            rem_sub;
  logic [pskf_pkg::PROD_P_W-1:0]         pred_ext;
  logic signed [pskf_pkg::PROD_D_W-1:0]  diff_ext;

  assign den_ext  = {1'b0, den_r};
  assign ge       = rem_r >= den_ext;
  // a zero denominator gives zero gain
  assign qbit     = ge & ~zero_r;
  assign rem_sub  = ge ? (rem_r - den_ext) : rem_r;
  assign pred_ext = pskf_pkg::PROD_P_W'(pred_r);
  assign diff_ext = pskf_pkg::PROD_D_W'(diff_r);

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    zero_nxt  = zero_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    pred_nxt  = pred_r;
    diff_nxt  = diff_r;
    quo_nxt   = quo_r;
    acc_p_nxt = acc_p_r;
    acc_d_nxt = acc_d_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = pskf_pkg::CNT_W'(pskf_pkg::GAIN_W - 1);
      zero_nxt  = (denom == '0);
      // pred is the numerator with its 16 zero fraction bits still to come
      rem_nxt   = pskf_pkg::REM_W'(pred);
      den_nxt   = denom;
      pred_nxt  = pred;
      diff_nxt  = diff;
      quo_nxt   = '0;
      acc_p_nxt = '0;
      acc_d_nxt = '0;
    end else if (busy_r) begin
      rem_nxt   = {rem_sub[pskf_pkg::REM_W-2:0], 1'b0};
      quo_nxt   = {quo_r[pskf_pkg::GAIN_W-2:0], qbit};
      acc_p_nxt = {acc_p_r[pskf_pkg::PROD_P_W-2:0], 1'b0} + (qbit ? pred_ext : '0);
      acc_d_nxt = (acc_d_r <<< 1) + (qbit ? diff_ext : '0);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - pskf_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zero_r  <= zero_nxt;
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    pred_r  <= pred_nxt;
    diff_r  <= diff_nxt;
    quo_r   <= quo_nxt;
    acc_p_r <= acc_p_nxt;
    acc_d_r <= acc_d_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign gain        = quo_r;
  assign prod_pred   = acc_p_r;
  assign prod_diff   = acc_d_r;

endmodule

@@ hw/rtl/per_channel_scalar_kalman_filter_core.sv @@
// top level of the per-channel scalar kalman filter core
//
//   channel   signals                                   direction
//   in_       in_valid, in_stall, in_channel,           sample beat into the core
//             in_raw_sample, in_previous_estimate
//   out_      out_valid, out_stall, out_estimate,       result beat out of the core
//             out_gain
//   cfg_      cfg_valid, cfg_ready, cfg_index,          register write beat
//             cfg_data
//
// one item at a time: no new beat is taken until the last item has been written out,
// and the bulk of each item is the 17-step bit-serial gain divide (one quotient bit per cycle)
// each item goes through predict, divider start, divide and a final step that fills the output register
// reset sets Q and R to their defaults and every channel variance to 1.0
// a stalled result waits in the output register; the core still takes and works
// on the next beat, holding only its final step until the register frees up
`include "per_channel_scalar_kalman_filter_core_defines.svh"

module per_channel_scalar_kalman_filter_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [pskf_pkg::CHANNEL_W-1:0]          in_channel,
  input  logic signed [pskf_pkg::SAMPLE_W-1:0]    in_raw_sample,
  input  logic signed [pskf_pkg::SAMPLE_W-1:0]    in_previous_estimate,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [pskf_pkg::SAMPLE_W-1:0]    out_estimate,
  output logic [pskf_pkg::GAIN_W-1:0]             out_gain,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [pskf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [pskf_pkg::VAR_W-1:0]              cfg_data
);

  pskf_pkg::pskf_state_t state_r, state_nxt;

  logic [pskf_pkg::VAR_W-1:0]              q_r, q_nxt;
  logic [pskf_pkg::VAR_W-1:0]              r_r, r_nxt;
  logic [pskf_pkg::IDX_W-1:0]              ch_r;
  logic signed [pskf_pkg::SAMPLE_W-1:0]    raw_r;
  logic signed [pskf_pkg::SAMPLE_W-1:0]    prev_r;
  logic [pskf_pkg::PRED_W-1:0]             pred_r;
  logic signed [pskf_pkg::DIFF_W-1:0]      diff_r;
  logic                                    out_valid_r, out_valid_nxt;
  logic signed [pskf_pkg::SAMPLE_W-1:0]    out_estimate_r;
  logic [pskf_pkg::GAIN_W-1:0]             out_gain_r;

  logic                                    in_fire;
  logic                                    load_item;
  logic                                    load_pred;
  logic                                    div_start;
  logic                                    fin_fire;
  logic                                    out_free;

  logic [pskf_pkg::VAR_W-1:0]              var_rd;
  logic [pskf_pkg::DENOM_W-1:0]            denom;
  logic [pskf_pkg::PRED_W-1:0]             pred_nxt;
  logic signed [pskf_pkg::DIFF_W-1:0]      diff_nxt;

  pskf_pkg::pskf_div_status_t              div_status;
  logic [pskf_pkg::GAIN_W-1:0]             div_gain;
  logic [pskf_pkg::PROD_P_W-1:0]           div_prod_p;
  logic signed [pskf_pkg::PROD_D_W-1:0]    div_prod_d;

  logic [pskf_pkg::DENOM_W-1:0]            var_dec;
  logic [pskf_pkg::VAR_W-1:0]              var_new;
  logic signed [pskf_pkg::SAMPLE_W+1:0]    est_wide;
  logic signed [pskf_pkg::SAMPLE_W-1:0]    est_nxt;

  // config registers
  assign cfg_ready = 1'b1;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pskf_pkg::REG_PROCESS_NOISE:     q_nxt = cfg_data;
        pskf_pkg::REG_OBSERVATION_NOISE: r_nxt = cfg_data;
        default: begin
          q_nxt = q_r;
          r_nxt = r_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= pskf_pkg::Q_RESET;
      r_r <= pskf_pkg::R_RESET;
    end else begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  // sequencer
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pskf_pkg::ST_IDLE:  if (in_valid) state_nxt = pskf_pkg::ST_PRED;
      pskf_pkg::ST_PRED:  state_nxt = pskf_pkg::ST_START;
      pskf_pkg::ST_START: state_nxt = pskf_pkg::ST_DIV;
      pskf_pkg::ST_DIV:   if (div_status.done) state_nxt = pskf_pkg::ST_FIN;
      pskf_pkg::ST_FIN:   if (out_free) state_nxt = pskf_pkg::ST_IDLE;
      default:            state_nxt = pskf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    load_item = 1'b0;
    load_pred = 1'b0;
    div_start = 1'b0;
    fin_fire  = 1'b0;
    unique case (state_r)
      pskf_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        load_item = in_valid;
      end
      pskf_pkg::ST_PRED:  load_pred = 1'b1;
      pskf_pkg::ST_START: div_start = 1'b1;
      pskf_pkg::ST_DIV:   in_stall  = 1'b1;
      pskf_pkg::ST_FIN:   fin_fire  = out_free;
      default:            in_stall  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pskf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item capture and predicted variance
  assign pred_nxt = pskf_pkg::PRED_W'(var_rd) + pskf_pkg::PRED_W'(q_r);
  assign diff_nxt = {raw_r[pskf_pkg::SAMPLE_W-1], raw_r}
                  - {prev_r[pskf_pkg::SAMPLE_W-1], prev_r};
  assign denom    = pskf_pkg::DENOM_W'(pred_r) + pskf_pkg::DENOM_W'(r_r);

  always_ff @(posedge clk) begin
    if (load_item) begin
      ch_r   <= pskf_pkg::CH_MAP[in_channel];
      raw_r  <= in_raw_sample;
      prev_r <= in_previous_estimate;
    end
    if (load_pred) begin
      pred_r <= pred_nxt;
      diff_r <= diff_nxt;
    end
  end

  pskf_var_store u_var_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (ch_r),
    .rd_data (var_rd),
    .wr_en   (fin_fire),
    .wr_idx  (ch_r),
    .wr_data (var_new)
  );

  pskf_serial_div u_serial_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .pred      (pred_r),
    .denom     (denom),
    .diff      (diff_r),
    .status    (div_status),
    .gain      (div_gain),
    .prod_pred (div_prod_p),
    .prod_diff (div_prod_d)
  );

  // new variance is pred minus the rounded-up top of gain*pred
  assign var_dec = {1'b0, pred_r}
                 - div_prod_p[pskf_pkg::PROD_P_W-1:pskf_pkg::FRAC_W]
                 - pskf_pkg::DENOM_W'(|div_prod_p[pskf_pkg::FRAC_W-1:0]);
  assign var_new = (var_dec > pskf_pkg::DENOM_W'(pskf_pkg::VAR_MAX))
                 ? pskf_pkg::VAR_MAX : var_dec[pskf_pkg::VAR_W-1:0];

  // arithmetic shift floors the scaled correction
  assign est_wide = {{2{prev_r[pskf_pkg::SAMPLE_W-1]}}, prev_r}
                  + div_prod_d[pskf_pkg::PROD_D_W-1:pskf_pkg::FRAC_W];
  assign est_nxt  = est_wide[pskf_pkg::SAMPLE_W-1:0];

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_estimate_r <= est_nxt;
      out_gain_r     <= div_gain;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_estimate = out_estimate_r;
  assign out_gain     = out_gain_r;

  `PSKF_ASSERT_NXT(a_accept_starts_item, in_fire,
    state_r == pskf_pkg::ST_PRED, "accepted beat did not start an item")
  `PSKF_ASSERT_IMP(a_gain_bound, out_valid, out_gain <= pskf_pkg::GAIN_ONE,
    "gain above one")
  `PSKF_ASSERT_IMP(a_est_between, fin_fire,
    (est_nxt >= prev_r && est_nxt <= raw_r) || (est_nxt <= prev_r && est_nxt >= raw_r),
    "estimate outside previous and raw")
  `PSKF_ASSERT_IMP(a_zero_denom_gain, fin_fire && denom == '0, div_gain == '0,
    "nonzero gain on zero denominator")
  `PSKF_ASSERT_IMP(a_start_when_idle, div_start, !div_status.busy,
    "divider started while busy")

endmodule
